>>> rtl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Request and response payload types, request modes and status codes of the
// ready queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

   localparam int PID_W  = 8;
   localparam int QCNT_W = 5;

   typedef enum logic [1:0] {
      MODE_ADD      = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_SCHEDULE = 2'd2,
      MODE_HEAD     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NONE      = 2'd3
   } status_type;

   typedef struct packed {
      mode_type          mode;
      logic [PID_W-1:0]  process_id;
      logic              finished;
      logic              drop;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PID_W-1:0]  selected_id;
      logic              selected_valid;
      logic [PID_W-1:0]  preempted_id;
      logic              preempted_valid;
      logic [QCNT_W-1:0] queue_count;
   } rsp_type;

endpackage

>>> rtl/rqs_store.sv
// ----------------------------------------------------------------------------
// rqs_store
// Queue entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rqs_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rqs_seq.sv
// ----------------------------------------------------------------------------
// rqs_seq
// Request sequencer: keeps head and count, walks the entry memory with
// read-modify-write steps and builds one response per request.
// ----------------------------------------------------------------------------
module rqs_seq #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rqs_pkg::req_type       req_data,
   input  logic                   round_robin,
   output logic                   res_valid,
   output rqs_pkg::rsp_type       res_data,
   input  logic                   out_free,
   output logic                   wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [ID_BITS-1:0]     wr_data,
   output logic                   rd_en,
   output logic [IDX_W-1:0]       rd_addr,
   input  logic [ID_BITS-1:0]     rd_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_HEAD_RD,
      ST_ROT_RD,
      ST_SEL_RD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT,
      ST_DONE
   } state_type;

   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W:0]   off);
      logic [CNT_W+1:0] sum;
      sum = (CNT_W+2)'(base) + (CNT_W+2)'(off);
      if (sum >= (CNT_W+2)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+2)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   rqs_pkg::req_type      op_ff, op_in;
   rqs_pkg::rsp_type      res_ff, res_in;

   logic [ID_BITS+rqs_pkg::PID_W-1:0]  pid_ext;
   logic [ID_BITS-1:0]                 op_id;
   logic [ID_BITS+rqs_pkg::PID_W-1:0]  rd_ext;
   logic [rqs_pkg::PID_W-1:0]          rd_pid;
   logic [CNT_W+rqs_pkg::QCNT_W-1:0]   cnt_ext;
   logic [CNT_W:0]                     cnt_x;
   logic [CNT_W:0]                     idx_x;
   logic [CNT_W:0]                     idx_p1;
   logic [CNT_W:0]                     idx_p2;
   logic [CNT_W:0]                     one_x;

   assign pid_ext = {{ID_BITS{1'b0}}, op_ff.process_id};
   assign op_id   = pid_ext[ID_BITS-1:0];
   assign rd_ext  = {{rqs_pkg::PID_W{1'b0}}, rd_data};
   assign rd_pid  = rd_ext[rqs_pkg::PID_W-1:0];
   assign cnt_ext = {{rqs_pkg::QCNT_W{1'b0}}, count_ff};
   assign cnt_x   = {1'b0, count_ff};
   assign idx_x   = {1'b0, idx_ff};
   assign idx_p1  = idx_x + (CNT_W+1)'(1);
   assign idx_p2  = idx_x + (CNT_W+1)'(2);
   assign one_x   = (CNT_W+1)'(1);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = slot_addr(head_ff, cnt_x);
      wr_data  = op_id;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               res_in   = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (op_ff.mode)
               rqs_pkg::MODE_ADD: begin
                  if (count_ff == DEPTH_CNT) begin
                     res_in.status = rqs_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end
               rqs_pkg::MODE_REMOVE: begin
                  if (count_ff == '0) begin
                     res_in.status = rqs_pkg::STATUS_NOT_FOUND;
                     state_in      = ST_DONE;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_SCAN_RD;
                  end
               end
               rqs_pkg::MODE_SCHEDULE: begin
                  if (count_ff <= CNT_W'(1)) begin
                     res_in.status = rqs_pkg::STATUS_NONE;
                     state_in      = ST_DONE;
                  end else if (round_robin && !op_ff.finished) begin
                     rd_en    = 1'b1;
                     state_in = ST_ROT_RD;
                  end else begin
                     head_in  = slot_addr(head_ff, one_x);
                     count_in = count_ff - CNT_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = slot_addr(head_ff, one_x);
                     state_in = ST_SEL_RD;
                  end
               end
               rqs_pkg::MODE_HEAD: begin
                  if (count_ff == '0) begin
                     res_in.status = rqs_pkg::STATUS_NONE;
                     state_in      = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_HEAD_RD;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_HEAD_RD: begin
            res_in.selected_id    = rd_pid;
            res_in.selected_valid = 1'b1;
            if (op_ff.drop) begin
               head_in  = slot_addr(head_ff, one_x);
               count_in = count_ff - CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_ROT_RD: begin
            wr_en                  = 1'b1;
            wr_data                = rd_data;
            res_in.preempted_id    = rd_pid;
            res_in.preempted_valid = 1'b1;
            head_in                = slot_addr(head_ff, one_x);
            rd_en                  = 1'b1;
            rd_addr                = slot_addr(head_ff, one_x);
            state_in               = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            res_in.selected_id    = rd_pid;
            res_in.selected_valid = 1'b1;
            state_in              = ST_DONE;
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_addr(head_ff, idx_x);
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(head_ff, idx_p1);
            if (rd_data == op_id) begin
               if (idx_p1 < cnt_x) begin
                  state_in = ST_SHIFT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_DONE;
               end
            end else if (idx_p1 == cnt_x) begin
               res_in.status = rqs_pkg::STATUS_NOT_FOUND;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_p1[CNT_W-1:0];
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_addr(head_ff, idx_x);
            wr_data = rd_data;
            idx_in  = idx_p1[CNT_W-1:0];
            if (idx_p2 < cnt_x) begin
               rd_en   = 1'b1;
               rd_addr = slot_addr(head_ff, idx_p2);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res_data             = res_ff;
      res_data.queue_count = cnt_ext[rqs_pkg::QCNT_W-1:0];
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond queue depth");

   a_rw_disjoint: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same entry in one cycle");

   a_head_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (head_ff != $past(head_ff)))
         |-> (head_ff == slot_addr($past(head_ff), one_x)))
      else $error("head moved by other than one entry");

   a_preempt_select: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ff.preempted_valid)
         |-> (res_ff.selected_valid && round_robin
              && (op_ff.mode == rqs_pkg::MODE_SCHEDULE)))
      else $error("preemption reported without a rotation");
`endif

endmodule

>>> rtl/ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// ready_queue_scheduler
// Ready queue of process identifiers with add, remove, schedule and head read.
// ----------------------------------------------------------------------------
// Handles one request at a time; the entries sit in a single-port-read,
// single-port-write memory and every request gives exactly one response,
// held in an output register so the next request may transfer while the
// previous response is stalled. A rotating schedule copies the head entry
// to the tail before it selects the next entry; a head read or schedule
// that finds nothing to return does not touch the entry memory. A remove
// reads the queue from the head one entry per cycle until it finds the
// identifier, then moves each entry behind it up by one, one entry per
// cycle, as the entry memory has one read and one write port; an empty
// queue gives not found without any read of the memory. The memory needs
// no clearing after reset. Write the round-robin register only while no
// request is in flight.
module ready_queue_scheduler #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rqs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rqs_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic                   round_robin_ff;
   logic                   rsp_valid_ff;
   rqs_pkg::rsp_type       rsp_data_ff;
   logic                   res_valid;
   rqs_pkg::rsp_type       res_data;
   logic                   out_free;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ID_BITS-1:0]     wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ID_BITS-1:0]     rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   rqs_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .round_robin (round_robin_ff),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .out_free    (out_free),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   rqs_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ID_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         round_robin_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            round_robin_ff <= csr_data;
         end
         if (res_valid && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
